// ----- rtl/pbkf_pkg.sv -----
// Package: types, constants and the micro-program of the position/bias Kalman filter.
package pbkf_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRACTION_BITS = 16;
   localparam int CFG_BITS = 31;
   localparam int CSR_INDEX_BITS = 2;
   localparam int DIV_BITS = WORD_BITS + FRACTION_BITS;
   localparam int STEP_BITS = 5;

   typedef logic signed [WORD_BITS-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam word_type FIX_ONE = word_type'(64'd1 << FRACTION_BITS);
   localparam word_type NOISE_DEFAULT =
      word_type'(((64'd1 << FRACTION_BITS) + 64'd500) / 64'd1000);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_Q_POSITION = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Q_BIAS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_R_POSITION = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERIOD = 2'd3;

   typedef struct packed {
      logic signed [31:0] measured_position;
      logic signed [31:0] commanded_speed;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] position_estimate;
      logic signed [31:0] speed_estimate;
      logic signed [31:0] bias_estimate;
   } rsp_word_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_END
   } op_type;

   typedef enum logic [4:0] {
      SEL_ZERO,
      SEL_POS,
      SEL_BIAS,
      SEL_PP,
      SEL_PB,
      SEL_BP,
      SEL_BB,
      SEL_TMP,
      SEL_PRD,
      SEL_E,
      SEL_K0,
      SEL_K1,
      SEL_ERR,
      SEL_CMD,
      SEL_MEAS,
      SEL_DT,
      SEL_QP,
      SEL_QB,
      SEL_R
   } sel_type;

   typedef struct packed {
      op_type op;
      sel_type a;
      sel_type b;
      sel_type dst;
   } uop_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WB,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam logic [STEP_BITS-1:0] STEP_LAST = 5'd30;

   // predict, gains, measurement update, covariance shrink
   function automatic uop_type uop_at(input logic [STEP_BITS-1:0] step);
      uop_type u;
      u = '{OP_END, SEL_ZERO, SEL_ZERO, SEL_ZERO};
      case (step)
         5'd0:  u = '{OP_SUB, SEL_CMD, SEL_BIAS, SEL_TMP};
         5'd1:  u = '{OP_MUL, SEL_TMP, SEL_DT, SEL_PRD};
         5'd2:  u = '{OP_ADD, SEL_POS, SEL_PRD, SEL_POS};
         5'd3:  u = '{OP_SUB, SEL_QP, SEL_PB, SEL_TMP};
         5'd4:  u = '{OP_SUB, SEL_TMP, SEL_BP, SEL_TMP};
         5'd5:  u = '{OP_MUL, SEL_TMP, SEL_DT, SEL_PRD};
         5'd6:  u = '{OP_ADD, SEL_PP, SEL_PRD, SEL_PP};
         5'd7:  u = '{OP_SUB, SEL_ZERO, SEL_BB, SEL_TMP};
         5'd8:  u = '{OP_MUL, SEL_TMP, SEL_DT, SEL_PRD};
         5'd9:  u = '{OP_ADD, SEL_PB, SEL_PRD, SEL_PB};
         5'd10: u = '{OP_ADD, SEL_BP, SEL_PRD, SEL_BP};
         5'd11: u = '{OP_MUL, SEL_QB, SEL_DT, SEL_PRD};
         5'd12: u = '{OP_ADD, SEL_BB, SEL_PRD, SEL_BB};
         5'd13: u = '{OP_ADD, SEL_R, SEL_PP, SEL_E};
         5'd14: u = '{OP_DIV, SEL_PP, SEL_E, SEL_K0};
         5'd15: u = '{OP_DIV, SEL_BP, SEL_E, SEL_K1};
         5'd16: u = '{OP_SUB, SEL_MEAS, SEL_POS, SEL_ERR};
         5'd17: u = '{OP_MUL, SEL_K0, SEL_ERR, SEL_PRD};
         5'd18: u = '{OP_ADD, SEL_POS, SEL_PRD, SEL_POS};
         5'd19: u = '{OP_MUL, SEL_K1, SEL_ERR, SEL_PRD};
         5'd20: u = '{OP_ADD, SEL_BIAS, SEL_PRD, SEL_BIAS};
         5'd21: u = '{OP_SUB, SEL_CMD, SEL_BIAS, SEL_TMP};
         5'd22: u = '{OP_MUL, SEL_K1, SEL_PP, SEL_PRD};
         5'd23: u = '{OP_SUB, SEL_BP, SEL_PRD, SEL_BP};
         5'd24: u = '{OP_MUL, SEL_K1, SEL_PB, SEL_PRD};
         5'd25: u = '{OP_SUB, SEL_BB, SEL_PRD, SEL_BB};
         5'd26: u = '{OP_MUL, SEL_K0, SEL_PP, SEL_PRD};
         5'd27: u = '{OP_SUB, SEL_PP, SEL_PRD, SEL_PP};
         5'd28: u = '{OP_MUL, SEL_K0, SEL_PB, SEL_PRD};
         5'd29: u = '{OP_SUB, SEL_PB, SEL_PRD, SEL_PB};
         default: u = '{OP_END, SEL_ZERO, SEL_ZERO, SEL_ZERO};
      endcase
      return u;
   endfunction

endpackage

// ----- rtl/pbkf_alu.sv -----
// Shared saturating add/subtract and rounded fixed-point multiply, result in the next cycle.
module pbkf_alu (
   input  logic               clock,
   input  pbkf_pkg::op_type   op,
   input  pbkf_pkg::word_type a,
   input  pbkf_pkg::word_type b,
   output pbkf_pkg::word_type result
);

   localparam int W = pbkf_pkg::WORD_BITS;
   localparam int F = pbkf_pkg::FRACTION_BITS;

   pbkf_pkg::op_type op_ff;
   logic [2*W-1:0] prod_ff;
   logic neg_ff;
   logic signed [W:0] sum_ff;

   logic [W-1:0] a_mag, b_mag;
   logic signed [W:0] sum_in;
   logic [2*W:0] rnd;
   logic [2*W-F:0] pmag;
   logic pbig;

   always_comb begin
      a_mag = a[W-1] ? (~W'(a) + W'(1)) : W'(a);
      b_mag = b[W-1] ? (~W'(b) + W'(1)) : W'(b);
      if (op == pbkf_pkg::OP_SUB) begin
         sum_in = {a[W-1], a} - {b[W-1], b};
      end else begin
         sum_in = {a[W-1], a} + {b[W-1], b};
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op;
      prod_ff <= a_mag * b_mag;
      neg_ff <= a[W-1] ^ b[W-1];
      sum_ff <= sum_in;
   end

   always_comb begin
      rnd = {1'b0, prod_ff} + (2*W+1)'(1 << (F-1));
      pmag = rnd[2*W:F];
      pbig = |pmag[2*W-F:W-1];
      result = '0;
      case (op_ff)
         pbkf_pkg::OP_MUL: begin
            if (neg_ff) begin
               result = pbig ? pbkf_pkg::WORD_MIN : -$signed(W'(pmag));
            end else begin
               result = pbig ? pbkf_pkg::WORD_MAX : $signed(W'(pmag));
            end
         end
         default: begin
            if (sum_ff[W] != sum_ff[W-1]) begin
               result = sum_ff[W] ? pbkf_pkg::WORD_MIN : pbkf_pkg::WORD_MAX;
            end else begin
               result = sum_ff[W-1:0];
            end
         end
      endcase
   end

endmodule

// ----- rtl/pbkf_div.sv -----
// Restoring radix-2 divider for the Kalman gains, one quotient bit per cycle.
module pbkf_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  pbkf_pkg::word_type num,
   input  pbkf_pkg::word_type den,
   output logic               done,
   output pbkf_pkg::word_type quo
);

   localparam int W = pbkf_pkg::WORD_BITS;
   localparam int F = pbkf_pkg::FRACTION_BITS;
   localparam int D = pbkf_pkg::DIV_BITS;
   localparam int CB = $clog2(D);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [D-1:0] dvd_ff, dvd_in;
   logic [D-1:0] quo_ff, quo_in;
   logic [W-1:0] den_ff, den_in;
   logic neg_ff, neg_in;
   logic zero_ff, zero_in;

   logic [W-1:0] n_mag, d_mag;
   logic [W:0] trial;
   logic ge;

   always_comb begin
      n_mag = num[W-1] ? (~W'(num) + W'(1)) : W'(num);
      d_mag = den[W-1] ? (~W'(den) + W'(1)) : W'(den);
      trial = {rem_ff, dvd_ff[D-1]};
      ge = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         dvd_in = {n_mag, {F{1'b0}}};
         quo_in = '0;
         den_in = d_mag;
         neg_in = num[W-1] ^ den[W-1];
         zero_in = (den == '0);
      end else if (busy_ff) begin
         rem_in = ge ? W'(trial - {1'b0, den_ff}) : W'(trial);
         quo_in = {quo_ff[D-2:0], ge};
         dvd_in = {dvd_ff[D-2:0], 1'b0};
         cnt_in = cnt_ff + CB'(1);
         if (cnt_ff == CB'(D-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      zero_ff <= zero_in;
   end

   logic big;

   always_comb begin
      big = |quo_ff[D-1:W-1];
      if (zero_ff) begin
         quo = '0;
      end else if (neg_ff) begin
         quo = big ? pbkf_pkg::WORD_MIN : -$signed(quo_ff[W-1:0]);
      end else begin
         quo = big ? pbkf_pkg::WORD_MAX : $signed(quo_ff[W-1:0]);
      end
   end

   assign done = done_ff;

endmodule

// ----- rtl/position_bias_kalman_filter_unit.sv -----
// Top level: two-state position/bias Kalman filter with micro-programmed sequencer.
//
//  channel  dir  handshake            word
//  req_     in   req_valid/req_stall  measured_position, commanded_speed
//  rsp_     out  rsp_valid/rsp_stall  position_estimate, speed_estimate, bias_estimate
//  csr_     in   csr_valid/csr_ready  csr_index, csr_data (Q, Q_bias, R, dt)
//
// Sequencing: each of the 28 ALU ops passes an issue state and a writeback state
//   through the shared multiplier/adder, and each of the two gain divisions waits
//   for the 48 quotient bits of the serial divider; accept and finish come on top.
// The shared ALU and the single serial divider set the time a word takes.
// Reset is synchronous; it restores the filter state (P = identity) and register defaults.
// req_stall is high while a word is in flight; a finished word waits in the rsp
//   register while the next req word can already be taken.
// csr_ready is always high and a write lands at once; send writes only while idle.
module position_bias_kalman_filter_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  pbkf_pkg::req_word_type                 req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output pbkf_pkg::rsp_word_type                 rsp_word,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pbkf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [pbkf_pkg::CFG_BITS-1:0]          csr_data
);

   localparam int W = pbkf_pkg::WORD_BITS;
   localparam int SB = pbkf_pkg::STEP_BITS;

   // configuration registers
   pbkf_pkg::word_type qp_ff, qb_ff, r_ff, dt_ff;

   // filter state and scratch
   pbkf_pkg::word_type pos_ff, bias_ff, pp_ff, pb_ff, bp_ff, bb_ff;
   pbkf_pkg::word_type tmp_ff, prd_ff, e_ff, k0_ff, k1_ff, err_ff;
   pbkf_pkg::word_type meas_ff, cmd_ff;

   pbkf_pkg::state_type state_ff, state_in;
   logic [SB-1:0] step_ff, step_in;

   logic rsp_valid_ff, rsp_valid_in;
   pbkf_pkg::rsp_word_type rsp_word_ff;

   pbkf_pkg::uop_type uop;
   pbkf_pkg::word_type opa, opb, alu_result, div_quo, wb_val;
   logic div_start, div_done, wb_en, accept, rsp_load;

   assign uop = pbkf_pkg::uop_at(step_ff);
   assign accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   function automatic pbkf_pkg::word_type pick(
      input pbkf_pkg::sel_type s,
      input pbkf_pkg::word_type pos, input pbkf_pkg::word_type bias,
      input pbkf_pkg::word_type pp, input pbkf_pkg::word_type pb,
      input pbkf_pkg::word_type bp, input pbkf_pkg::word_type bb,
      input pbkf_pkg::word_type tmp, input pbkf_pkg::word_type prd,
      input pbkf_pkg::word_type e, input pbkf_pkg::word_type k0,
      input pbkf_pkg::word_type k1, input pbkf_pkg::word_type err,
      input pbkf_pkg::word_type cmd, input pbkf_pkg::word_type meas,
      input pbkf_pkg::word_type dt, input pbkf_pkg::word_type qp,
      input pbkf_pkg::word_type qb, input pbkf_pkg::word_type r);
      pbkf_pkg::word_type v;
      v = '0;
      case (s)
         pbkf_pkg::SEL_POS:  v = pos;
         pbkf_pkg::SEL_BIAS: v = bias;
         pbkf_pkg::SEL_PP:   v = pp;
         pbkf_pkg::SEL_PB:   v = pb;
         pbkf_pkg::SEL_BP:   v = bp;
         pbkf_pkg::SEL_BB:   v = bb;
         pbkf_pkg::SEL_TMP:  v = tmp;
         pbkf_pkg::SEL_PRD:  v = prd;
         pbkf_pkg::SEL_E:    v = e;
         pbkf_pkg::SEL_K0:   v = k0;
         pbkf_pkg::SEL_K1:   v = k1;
         pbkf_pkg::SEL_ERR:  v = err;
         pbkf_pkg::SEL_CMD:  v = cmd;
         pbkf_pkg::SEL_MEAS: v = meas;
         pbkf_pkg::SEL_DT:   v = dt;
         pbkf_pkg::SEL_QP:   v = qp;
         pbkf_pkg::SEL_QB:   v = qb;
         pbkf_pkg::SEL_R:    v = r;
         default:            v = '0;
      endcase
      return v;
   endfunction

   assign opa = pick(uop.a, pos_ff, bias_ff, pp_ff, pb_ff, bp_ff, bb_ff, tmp_ff, prd_ff,
                     e_ff, k0_ff, k1_ff, err_ff, cmd_ff, meas_ff, dt_ff, qp_ff, qb_ff, r_ff);
   assign opb = pick(uop.b, pos_ff, bias_ff, pp_ff, pb_ff, bp_ff, bb_ff, tmp_ff, prd_ff,
                     e_ff, k0_ff, k1_ff, err_ff, cmd_ff, meas_ff, dt_ff, qp_ff, qb_ff, r_ff);

   pbkf_alu u_alu (
      .clock  (clock),
      .op     (uop.op),
      .a      (opa),
      .b      (opb),
      .result (alu_result)
   );

   pbkf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (opa),
      .den   (opb),
      .done  (div_done),
      .quo   (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      case (state_ff)
         pbkf_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = pbkf_pkg::ST_ISSUE;
               step_in = '0;
            end
         end
         pbkf_pkg::ST_ISSUE: begin
            case (uop.op)
               pbkf_pkg::OP_END: state_in = pbkf_pkg::ST_DONE;
               pbkf_pkg::OP_DIV: state_in = pbkf_pkg::ST_DIV;
               default:          state_in = pbkf_pkg::ST_WB;
            endcase
         end
         pbkf_pkg::ST_WB: begin
            state_in = pbkf_pkg::ST_ISSUE;
            step_in = step_ff + SB'(1);
         end
         pbkf_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = pbkf_pkg::ST_ISSUE;
               step_in = step_ff + SB'(1);
            end
         end
         pbkf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = pbkf_pkg::ST_IDLE;
            end
         end
         default: state_in = pbkf_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      wb_en = 1'b0;
      wb_val = alu_result;
      rsp_load = 1'b0;
      case (state_ff)
         pbkf_pkg::ST_IDLE:  req_stall = 1'b0;
         pbkf_pkg::ST_ISSUE: div_start = (uop.op == pbkf_pkg::OP_DIV);
         pbkf_pkg::ST_WB:    wb_en = 1'b1;
         pbkf_pkg::ST_DIV: begin
            wb_en = div_done;
            wb_val = div_quo;
         end
         pbkf_pkg::ST_DONE:  rsp_load = !rsp_valid_ff || !rsp_stall;
         default:            req_stall = 1'b1;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbkf_pkg::ST_IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
         qp_ff <= pbkf_pkg::FIX_ONE;
         qb_ff <= pbkf_pkg::FIX_ONE;
         r_ff <= pbkf_pkg::NOISE_DEFAULT;
         dt_ff <= pbkf_pkg::FIX_ONE;
         pos_ff <= '0;
         bias_ff <= '0;
         pp_ff <= pbkf_pkg::FIX_ONE;
         pb_ff <= '0;
         bp_ff <= '0;
         bb_ff <= pbkf_pkg::FIX_ONE;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pbkf_pkg::CSR_Q_POSITION: qp_ff <= W'(csr_data);
               pbkf_pkg::CSR_Q_BIAS:     qb_ff <= W'(csr_data);
               pbkf_pkg::CSR_R_POSITION: r_ff <= W'(csr_data);
               pbkf_pkg::CSR_PERIOD:     dt_ff <= W'(csr_data);
               default:                  qp_ff <= qp_ff;
            endcase
         end
         if (wb_en) begin
            case (uop.dst)
               pbkf_pkg::SEL_POS:  pos_ff <= wb_val;
               pbkf_pkg::SEL_BIAS: bias_ff <= wb_val;
               pbkf_pkg::SEL_PP:   pp_ff <= wb_val;
               pbkf_pkg::SEL_PB:   pb_ff <= wb_val;
               pbkf_pkg::SEL_BP:   bp_ff <= wb_val;
               pbkf_pkg::SEL_BB:   bb_ff <= wb_val;
               default:            pos_ff <= pos_ff;
            endcase
         end
      end
      // scratch registers carry payload only
      if (wb_en) begin
         case (uop.dst)
            pbkf_pkg::SEL_TMP: tmp_ff <= wb_val;
            pbkf_pkg::SEL_PRD: prd_ff <= wb_val;
            pbkf_pkg::SEL_E:   e_ff <= wb_val;
            pbkf_pkg::SEL_K0:  k0_ff <= wb_val;
            pbkf_pkg::SEL_K1:  k1_ff <= wb_val;
            pbkf_pkg::SEL_ERR: err_ff <= wb_val;
            default:           tmp_ff <= tmp_ff;
         endcase
      end
      if (accept) begin
         meas_ff <= req_word.measured_position;
         cmd_ff <= req_word.commanded_speed;
      end
      // speed sits in tmp after the bias update
      if (rsp_load) begin
         rsp_word_ff <= '{pos_ff, tmp_ff, bias_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == pbkf_pkg::ST_DIV)
      else $error("divider finished outside a divide step");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= pbkf_pkg::STEP_LAST)
      else $error("micro-program step out of range");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == pbkf_pkg::ST_ISSUE && step_ff == '0)
      else $error("accepted word did not start the program");

   a_load_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && state_ff == pbkf_pkg::ST_IDLE)
      else $error("result load did not post a word and return to idle");

endmodule
